// ===== hw/rtl/ich_pkg.sv =====
// Shared types and constants for the image channel histogram.
`timescale 1ns / 1ps
`default_nettype none
package ich_pkg;
    localparam int MAX_BINS    = 256;
    localparam int BIN_BITS    = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 32;
    localparam int NCNT_BITS   = 9;
    localparam int QUO_BITS    = 8;
    localparam int NUM_BITS    = NCNT_BITS + SAMPLE_BITS;
    localparam int DSH_BITS    = SAMPLE_BITS + 1 + QUO_BITS - 1;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] CFG_CLIP_MODE  = 2'd0;
    localparam logic [1:0] CFG_BIN_COUNT  = 2'd1;
    localparam logic [1:0] CFG_MIN_VALUE  = 2'd2;
    localparam logic [1:0] CFG_VALUE_SPAN = 2'd3;

    typedef enum logic [1:0] {
        K_ADD,
        K_READ,
        K_CLEAR,
        K_FLAG
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [BIN_BITS-1:0] idx;
        logic                oor;
    } t_cmd;

    typedef struct packed {
        logic                   clip_mode;
        logic [NCNT_BITS-1:0]   bin_count;
        logic [SAMPLE_BITS-1:0] min_value;
        logic [SAMPLE_BITS-1:0] value_span;
    } t_cfg;
endpackage
`default_nettype wire

// ===== hw/rtl/ich_front.sv =====
// Front end: accepts transactions, classifies them and computes the bin index.
`timescale 1ns / 1ps
`default_nettype none
module ich_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire ich_pkg::t_cfg                   i_cfg,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [1:0]                      i_opcode,
    input  wire logic [ich_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire logic [ich_pkg::BIN_BITS-1:0]    i_bin_select,
    output logic                                 o_push,
    output ich_pkg::t_cmd                        o_cmd,
    input  wire logic                            i_push_ready
);
    import ich_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_DIV,
        F_PUSH
    } t_fstate;

    t_fstate                r_state;
    t_cmd                   r_cmd;
    logic [SAMPLE_BITS-1:0] r_d;
    logic [NUM_BITS-1:0]    r_num;
    logic [DSH_BITS-1:0]    r_dsh;
    logic [QUO_BITS-1:0]    r_quo;
    logic [2:0]             r_step;

    logic [NCNT_BITS-1:0]   n_bins;
    logic                   direct;
    logic signed [SAMPLE_BITS:0] diff;
    logic                   ge;
    logic [QUO_BITS-1:0]    n_quo;
    logic [SAMPLE_BITS:0]   divisor;

    always_comb begin
        if (i_cfg.bin_count < NCNT_BITS'(2)) begin
            n_bins = NCNT_BITS'(2);
        end else if (i_cfg.bin_count > NCNT_BITS'(MAX_BINS)) begin
            n_bins = NCNT_BITS'(MAX_BINS);
        end else begin
            n_bins = i_cfg.bin_count;
        end
        direct  = i_cfg.clip_mode && (n_bins == NCNT_BITS'(MAX_BINS));
        diff    = $signed({i_sample[SAMPLE_BITS-1], i_sample})
                - $signed({i_cfg.min_value[SAMPLE_BITS-1], i_cfg.min_value});
        divisor = {1'b0, i_cfg.value_span} + (SAMPLE_BITS+1)'(1);
        ge      = r_num >= {1'b0, r_dsh};
        n_quo   = {r_quo[QUO_BITS-2:0], ge};
    end

    assign o_stall = (r_state != F_IDLE);
    assign o_push  = (r_state == F_PUSH);
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_state <= F_PUSH;
                        case (i_opcode)
                            OP_ADD: begin
                                if (direct) begin
                                    r_cmd.kind <= K_ADD;
                                    r_cmd.oor  <= 1'b0;
                                    if (i_sample[SAMPLE_BITS-1]) begin
                                        r_cmd.idx <= '0;
                                    end else if (i_sample > SAMPLE_BITS'(MAX_BINS - 1)) begin
                                        r_cmd.idx <= BIN_BITS'(MAX_BINS - 1);
                                    end else begin
                                        r_cmd.idx <= i_sample[BIN_BITS-1:0];
                                    end
                                end else if (diff[SAMPLE_BITS] ||
                                             diff[SAMPLE_BITS-1:0] > i_cfg.value_span) begin
                                    r_cmd.kind <= K_FLAG;
                                    r_cmd.idx  <= '0;
                                    r_cmd.oor  <= 1'b1;
                                end else begin
                                    r_d     <= diff[SAMPLE_BITS-1:0];
                                    r_state <= F_MUL;
                                end
                            end
                            OP_READ: begin
                                r_cmd.kind <= K_READ;
                                r_cmd.idx  <= i_bin_select;
                                r_cmd.oor  <= 1'b0;
                            end
                            OP_CLEAR: begin
                                r_cmd.kind <= K_CLEAR;
                                r_cmd.idx  <= i_bin_select;
                                r_cmd.oor  <= 1'b0;
                            end
                            default: begin
                                r_cmd.kind <= K_FLAG;
                                r_cmd.idx  <= i_bin_select;
                                r_cmd.oor  <= 1'b0;
                            end
                        endcase
                    end
                end
                F_MUL: begin
                    r_num   <= NUM_BITS'(n_bins) * NUM_BITS'(r_d);
                    r_dsh   <= {divisor, (QUO_BITS-1)'(0)};
                    r_quo   <= '0;
                    r_step  <= 3'(QUO_BITS - 1);
                    r_state <= F_DIV;
                end
                F_DIV: begin
                    if (ge) begin
                        r_num <= r_num - NUM_BITS'(r_dsh);
                    end
                    r_dsh <= r_dsh >> 1;
                    r_quo <= n_quo;
                    r_step <= r_step - 3'd1;
                    if (r_step == 3'd0) begin
                        r_cmd.kind <= K_ADD;
                        r_cmd.idx  <= n_quo;
                        r_cmd.oor  <= 1'b0;
                        r_state    <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (i_push_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/ich_queue.sv =====
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module ich_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ich_pkg::t_cmd i_cmd,
    output logic               o_ready,
    output logic               o_valid,
    output ich_pkg::t_cmd      o_cmd,
    input  wire logic          i_pop
);
    import ich_pkg::*;

    t_cmd       r_entry [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_entry[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/ich_back.sv =====
// Back end: bin counter memory with read-modify-write and the result register.
`timescale 1ns / 1ps
`default_nettype none
module ich_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire ich_pkg::t_cmd                  i_cmd,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [ich_pkg::BIN_BITS-1:0]        o_bin_index,
    output logic [ich_pkg::COUNT_BITS-1:0]      o_bin_value,
    output logic                                o_out_of_range
);
    import ich_pkg::*;

    typedef enum logic {
        B_IDLE,
        B_EXEC
    } t_bstate;

    t_bstate               r_state;
    t_cmd                  r_cmd;
    logic [COUNT_BITS-1:0] r_mem [MAX_BINS];
    logic [MAX_BINS-1:0]   r_valid;
    logic [COUNT_BITS-1:0] r_rdata;
    logic                  r_rvld;
    logic                  r_out_valid;
    logic [BIN_BITS-1:0]   r_idx;
    logic [COUNT_BITS-1:0] r_val;
    logic                  r_oor;

    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] inc;
    logic                  wr_en;
    logic [COUNT_BITS-1:0] wr_data;

    always_comb begin
        cur     = r_rvld ? r_rdata : '0;
        inc     = (&cur) ? cur : cur + COUNT_BITS'(1);
        wr_en   = (r_state == B_EXEC) && (r_cmd.kind == K_ADD || r_cmd.kind == K_CLEAR);
        wr_data = (r_cmd.kind == K_ADD) ? inc : '0;
    end

    assign o_pop          = (r_state == B_IDLE) && i_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid    = r_out_valid;
    assign o_bin_index    = r_idx;
    assign o_bin_value    = r_val;
    assign o_out_of_range = r_oor;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rdata <= r_mem[i_cmd.idx];
        end
        if (wr_en) begin
            r_mem[r_cmd.idx] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        r_cmd   <= i_cmd;
                        r_rvld  <= r_valid[i_cmd.idx];
                        r_state <= B_EXEC;
                    end
                end
                B_EXEC: begin
                    if (wr_en) begin
                        r_valid[r_cmd.idx] <= 1'b1;
                    end
                    r_idx       <= r_cmd.idx;
                    r_oor       <= r_cmd.oor;
                    r_out_valid <= 1'b1;
                    case (r_cmd.kind)
                        K_ADD:   r_val <= inc;
                        K_READ:  r_val <= cur;
                        K_CLEAR: r_val <= cur;
                        default: r_val <= '0;
                    endcase
                    r_state <= B_IDLE;
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/image_channel_histogram.sv =====
// Top level of the image channel histogram with its configuration registers.
//
//   Channel   Direction  Handshake             Payload
//   in        input      i_in_valid/o_in_stall   i_opcode, i_sample, i_bin_select
//   out       output     o_out_valid/i_out_stall o_bin_index, o_bin_value, o_out_of_range
//   cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A read, clear, clipped add or out-of-range add goes from F_IDLE straight to F_PUSH in the
// front end; a scaled add first passes F_MUL and F_DIV, where the restoring divider yields one quotient bit per cycle.
// The back end reads the counter memory as it pops a transaction and writes it back in B_EXEC.
// Reset clears all bins at once through per-bin valid bits; no clearing pass is needed.
// A stalled result holds the back end; the queue then fills and stalls the input.
`timescale 1ns / 1ps
`default_nettype none
module image_channel_histogram (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [1:0]                      i_opcode,
    input  wire logic [ich_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire logic [ich_pkg::BIN_BITS-1:0]    i_bin_select,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [ich_pkg::BIN_BITS-1:0]         o_bin_index,
    output logic [ich_pkg::COUNT_BITS-1:0]       o_bin_value,
    output logic                                 o_out_of_range,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [1:0]                      i_cfg_index,
    input  wire logic [ich_pkg::SAMPLE_BITS-1:0] i_cfg_data
);
    import ich_pkg::*;

    t_cfg r_cfg;
    logic q_push;
    t_cmd q_in;
    logic q_ready;
    logic q_valid;
    t_cmd q_out;
    logic q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clip_mode  <= 1'b1;
            r_cfg.bin_count  <= NCNT_BITS'(MAX_BINS);
            r_cfg.min_value  <= '0;
            r_cfg.value_span <= SAMPLE_BITS'(255);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CLIP_MODE:  r_cfg.clip_mode  <= i_cfg_data[0];
                CFG_BIN_COUNT:  r_cfg.bin_count  <= i_cfg_data[NCNT_BITS-1:0];
                CFG_MIN_VALUE:  r_cfg.min_value  <= i_cfg_data;
                CFG_VALUE_SPAN: r_cfg.value_span <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ich_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_opcode     (i_opcode),
        .i_sample     (i_sample),
        .i_bin_select (i_bin_select),
        .o_push       (q_push),
        .o_cmd        (q_in),
        .i_push_ready (q_ready)
    );

    ich_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_out),
        .i_pop   (q_pop)
    );

    ich_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_cmd          (q_out),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_bin_index    (o_bin_index),
        .o_bin_value    (o_bin_value),
        .o_out_of_range (o_out_of_range)
    );
endmodule
`default_nettype wire
